// File: hdl/srg_pkg.sv
`timescale 1ns / 1ps

package srg_pkg;

  // Table geometry and word widths.
  localparam int unsigned TableLen = 55;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned ValW     = 30;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [ValW-1:0] val_t;

  // Arithmetic constants of the generator.
  localparam val_t Modulus   = 30'd1000000000;
  localparam val_t SeedReset = 30'd161803398;

  // Index constants. The table is addressed 1 to TableLen.
  localparam idx_t LastIdx     = idx_t'(TableLen);
  localparam idx_t FillLast    = idx_t'(TableLen - 1);
  localparam idx_t Spread      = 6'd21;
  localparam idx_t TrailStart  = 6'd31;
  localparam idx_t FirstLead   = 6'd1;
  localparam idx_t FirstTrail  = 6'd32;
  localparam logic [1:0] LastPass = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_MIX,
    S_DRAW
  } srg_state_e;

  // One write port and two read ports of the lag table.
  typedef struct packed {
    logic we;
    idx_t waddr;
    val_t wdata;
    logic re;
    idx_t raddr_a;
    idx_t raddr_b;
  } srg_ram_req_t;

  // Difference of two residues, wrapped back into [0, Modulus).
  function automatic val_t sub_mod(input val_t a, input val_t b);
    logic [ValW:0] wrapped;
    wrapped = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
    if (a >= b) begin
      return a - b;
    end else begin
      return wrapped[ValW-1:0];
    end
  endfunction

  // Step an index through 1 to TableLen, wrapping to 1.
  function automatic idx_t next_index(input idx_t x);
    if (x >= LastIdx) begin
      return FirstLead;
    end else begin
      return x + 1'b1;
    end
  endfunction

endpackage

// File: hdl/srg_lag_ram.sv
`timescale 1ns / 1ps

module srg_lag_ram
  import srg_pkg::*;
(
  input  logic         clk_i,
  input  srg_ram_req_t req_i,
  output val_t         rd_a_o,
  output val_t         rd_b_o
);

  // Entry 0 is never addressed; the table lives at 1 to TableLen.
  val_t mem [0:TableLen];
  val_t rd_a_q;
  val_t rd_b_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Two registered read ports; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_a_q <= mem[req_i.raddr_a];
      rd_b_q <= mem[req_i.raddr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// File: hdl/srg_seq.sv
`timescale 1ns / 1ps

module srg_seq
  import srg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         restart_i,
  input  val_t         seed_i,
  input  logic         out_free_i,
  output logic         out_load_o,
  output val_t         out_value_o,
  output srg_ram_req_t ram_req_o,
  input  val_t         rd_a_i,
  input  val_t         rd_b_i
);

  srg_state_e state_q, state_d;
  logic       seeded_q, seeded_d;
  idx_t       lead_q, lead_d;
  idx_t       trail_q, trail_d;
  idx_t       step_q, step_d;
  idx_t       pos_q, pos_d;
  logic [1:0] pass_q, pass_d;
  logic       issue_q, issue_d;
  logic       wr_pend_q, wr_pend_d;
  idx_t       wr_addr_q, wr_addr_d;
  val_t       cur_q, cur_d;
  val_t       nxt_q, nxt_d;

  val_t         seed_mod;
  val_t         diff;
  logic [IdxW:0] pos_sum;

  // The seed is below twice the modulus, so one subtract reduces it.
  assign seed_mod = (seed_i >= Modulus) ? (seed_i - Modulus) : seed_i;
  assign diff     = sub_mod(rd_a_i, rd_b_i);
  assign pos_sum  = {1'b0, pos_q} + {1'b0, Spread};

  assign out_value_o = diff;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      seeded_q  <= 1'b0;
      lead_q    <= '0;
      trail_q   <= TrailStart;
      step_q    <= FirstLead;
      pos_q     <= FirstTrail;
      pass_q    <= '0;
      issue_q   <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      seeded_q  <= seeded_d;
      lead_q    <= lead_d;
      trail_q   <= trail_d;
      step_q    <= step_d;
      pos_q     <= pos_d;
      pass_q    <= pass_d;
      issue_q   <= issue_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  // Seeding datapath registers.
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    wr_addr_q <= wr_addr_d;
  end

  // Sequencer. Reads issued in one cycle never hit the entry written in that
  // cycle: the leading and trailing addresses stay 31 apart, so no forwarding
  // path is needed between the write port and the read ports.
  always_comb begin
    state_d    = state_q;
    seeded_d   = seeded_q;
    lead_d     = lead_q;
    trail_d    = trail_q;
    step_d     = step_q;
    pos_d      = pos_q;
    pass_d     = pass_q;
    issue_d    = issue_q;
    wr_pend_d  = wr_pend_q;
    wr_addr_d  = wr_addr_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    ram_req_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!seeded_q || restart_i) begin
            // Start seeding: the last entry takes the reduced seed.
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = LastIdx;
            ram_req_o.wdata = seed_mod;
            cur_d   = seed_mod;
            nxt_d   = val_t'(1);
            pos_d   = Spread;
            step_d  = FirstLead;
            state_d = S_FILL;
          end else begin
            lead_d  = next_index(lead_q);
            trail_d = next_index(trail_q);
            ram_req_o.re      = 1'b1;
            ram_req_o.raddr_a = lead_d;
            ram_req_o.raddr_b = trail_d;
            state_d = S_DRAW;
          end
        end
      end

      S_FILL: begin
        // Scatter the running differences at steps of 21 through the table.
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_q;
        ram_req_o.wdata = nxt_q;
        nxt_d = sub_mod(cur_q, nxt_q);
        cur_d = nxt_q;
        if (pos_sum >= (IdxW+1)'(TableLen)) begin
          pos_d = pos_sum[IdxW-1:0] - LastIdx;
        end else begin
          pos_d = pos_sum[IdxW-1:0];
        end
        if (step_q == FillLast) begin
          step_d    = FirstLead;
          pos_d     = FirstTrail;
          pass_d    = '0;
          issue_d   = 1'b1;
          wr_pend_d = 1'b0;
          state_d   = S_MIX;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      S_MIX: begin
        // Warm-up: read entry i and entry i+31, write back in the next cycle.
        if (wr_pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = wr_addr_q;
          ram_req_o.wdata = diff;
        end
        if (issue_q) begin
          ram_req_o.re      = 1'b1;
          ram_req_o.raddr_a = step_q;
          ram_req_o.raddr_b = pos_q;
          wr_pend_d = 1'b1;
          wr_addr_d = step_q;
          step_d    = next_index(step_q);
          pos_d     = next_index(pos_q);
          if (step_q == LastIdx) begin
            if (pass_q == LastPass) begin
              issue_d = 1'b0;
            end else begin
              pass_d = pass_q + 1'b1;
            end
          end
        end else begin
          // Last write-back goes out; the first draw reads alongside it.
          wr_pend_d = 1'b0;
          seeded_d  = 1'b1;
          lead_d    = FirstLead;
          trail_d   = FirstTrail;
          ram_req_o.re      = 1'b1;
          ram_req_o.raddr_a = FirstLead;
          ram_req_o.raddr_b = FirstTrail;
          state_d = S_DRAW;
        end
      end

      S_DRAW: begin
        // Write the new entry back and hand the word over together.
        if (out_free_i) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = lead_q;
          ram_req_o.wdata = diff;
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/subtractive_random_generator.sv
`timescale 1ns / 1ps
// Lagged subtractive generator, modulus 10^9, 55-entry lag table in RAM.
// A draw's RAM read is issued when its request is accepted; the subtract and
// write-back go out with the word into the output register, which waits while
// the previous word is not taken. A new request is taken only once it has loaded.
// Seeding (first request after reset, or restart set) first runs 54 table
// writes after the one at acceptance, then 4 warm-up passes of 55 pipelined
// read-modify-writes, then the last write-back.
// Reset (rst_ni low, asynchronous) clears control and restores the seed.

module subtractive_random_generator
  import srg_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ValW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            restart_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ValW-1:0] value_o
);

  val_t         seed_q;
  logic         out_valid_q, out_valid_d;
  val_t         value_q;
  logic         out_free;
  logic         out_load;
  val_t         out_value;
  srg_ram_req_t ram_req;
  val_t         rd_a;
  val_t         rd_b;

  // Seed register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // Output register: a new word may load as the old one is taken.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_q <= out_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  srg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .seed_i      (seed_q),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_value_o (out_value),
    .ram_req_o   (ram_req),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b)
  );

  srg_lag_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srg_pkg::*;

  localparam int          ClkHalf      = 5;
  localparam int          ResetCycles  = 12;
  localparam int          WarmupPasses = 4;
  localparam int          MaxWait      = 16;
  localparam int          SettleCycles = 10;
  localparam int unsigned CycleLimit   = 1000000;
  localparam val_t        SeedTop      = '1;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  val_t cfg_wdata_i = '0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  logic restart_i   = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  val_t value_o;

  // Mirror of the generator state, kept in step with accepted draw requests.
  val_t lag_mirror [1:TableLen];
  val_t seed_reg   = SeedReset;
  int   lead_pos   = 0;
  int   trail_pos  = int'(TrailStart);
  bit   is_seeded  = 1'b0;

  val_t        expected_values [$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps     = 1'b0;

  subtractive_random_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort a run that hangs.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("subtractive_random_generator test failed");
    $finish;
  end

  // Difference of two residues, brought back into [0, 10^9).
  function automatic val_t wrap_diff(input val_t a, input val_t b);
    int unsigned d;
    d = (a >= b) ? a - b : a + Modulus - b;
    return val_t'(d);
  endfunction

  function automatic int step_index(input int x);
    return (x + 1 > int'(TableLen) || x + 1 < 1) ? 1 : x + 1;
  endfunction

  // Fill the table along the 21-step permutation, then run the warm-up passes.
  function automatic void seed_lag_table();
    val_t cur;
    val_t nxt;
    int   pos;
    cur = seed_reg % Modulus;
    nxt = val_t'(1);
    lag_mirror[TableLen] = cur;
    for (int i = 1; i < int'(TableLen); i++) begin
      pos = (int'(Spread) * i) % int'(TableLen);
      lag_mirror[pos] = nxt;
      nxt = wrap_diff(cur, nxt);
      cur = lag_mirror[pos];
    end
    for (int p = 0; p < WarmupPasses; p++) begin
      for (int i = 1; i <= int'(TableLen); i++) begin
        pos = 1 + ((i + int'(TrailStart) - 1) % int'(TableLen));
        lag_mirror[i] = wrap_diff(lag_mirror[i], lag_mirror[pos]);
      end
    end
    lead_pos  = 0;
    trail_pos = int'(TrailStart);
    is_seeded = 1'b1;
  endfunction

  // Value that one draw request must return.
  function automatic val_t predict_draw(input bit restart);
    val_t v;
    if (!is_seeded || restart) begin
      seed_lag_table();
    end
    lead_pos  = step_index(lead_pos);
    trail_pos = step_index(trail_pos);
    v = wrap_diff(lag_mirror[lead_pos], lag_mirror[trail_pos]);
    lag_mirror[lead_pos] = v;
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Offer one draw request after a random gap and record its expected word.
  task automatic send_draw(input bit restart);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MaxWait);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    expected_values.push_back(predict_draw(restart));
  endtask

  // Stop offering requests and let every pending word come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_seed(input val_t value);
    wait_for_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    seed_reg = value;
  endtask

  // Receiver: random stall before each word, none while no_gaps is set.
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MaxWait);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare every accepted word with the oldest expected one.
  always @(posedge clk_i) begin : check_words
    val_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d", value_o));
      end else begin
        want = expected_values.pop_front();
        if (value_o !== want) begin
          report_mismatch($sformatf("value %0d, expected %0d", value_o, want));
        end
      end
    end
  end

  // The very first draw seeds the table from the reset seed, even without restart.
  task automatic test_first_draw_after_reset();
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b0);
    wait_for_results();
  endtask

  // Restart at the seed extremes, including values at and above 10^9.
  task automatic test_seed_extremes();
    val_t seeds [5];
    seeds = '{val_t'(0), val_t'(1), val_t'(999999999), val_t'(1000000000), SeedTop};
    foreach (seeds[k]) begin
      write_seed(seeds[k]);
      send_draw(1'b1);
      send_draw(1'b0);
      send_draw(1'b0);
    end
    wait_for_results();
  endtask

  // A new seed must not take effect until the next restart.
  task automatic test_seed_without_restart();
    write_seed(val_t'(12345));
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    wait_for_results();
  endtask

  // Back-to-back restarts with both sides streaming.
  task automatic test_back_to_back_restarts();
    no_gaps = 1'b1;
    send_draw(1'b1);
    send_draw(1'b1);
    send_draw(1'b0);
    wait_for_results();
    no_gaps = 1'b0;
  endtask

  // Long random streams over several seeds with occasional restarts.
  task automatic test_random_draws();
    val_t seed;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        2:       seed = val_t'($urandom_range(1000000000, int'(SeedTop)));
        4:       seed = val_t'($urandom_range(0, 999999999));
        default: seed = val_t'($urandom());
      endcase
      write_seed(seed);
      no_gaps = (phase % 3 == 1);
      send_draw(1'($urandom_range(0, 1)));
      for (int n = 1; n < 200; n++) begin
        // The sender holds off once until every word has drained.
        if (phase == 0 && n == 100) begin
          wait_for_results();
        end
        if (phase == 5) begin
          no_gaps = ((n / 40) % 2 == 1);
        end
        send_draw($urandom_range(0, 39) == 0);
      end
    end
    wait_for_results();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_first_draw_after_reset();
    test_seed_extremes();
    test_seed_without_restart();
    test_back_to_back_restarts();
    test_random_draws();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("subtractive_random_generator test passed");
    end else begin
      $display("subtractive_random_generator test failed");
    end
    $finish;
  end

endmodule
